>>> design/rgb2hsv_pkg.sv
// ============================================================================
// rgb2hsv_pkg
// Shared types and constants for the rgb to hsv pixel converter.
// ============================================================================
`default_nettype none

package rgb2hsv_pkg;

   // default number of fraction bits of the hue field
   localparam int HUE_FRAC_BITS_DEF = 6;

   // field widths
   localparam int CODE_W = 8;
   localparam int HUE_W  = 15;

   // packed stream widths
   localparam int REQ_DATA_W = 3 * CODE_W;
   localparam int RSP_DATA_W = 32;

   // integer hue numerator before scaling: 60*delta + offset*span < 2^17
   localparam int BASE_W = 17;

   // hue quotient integer bits: 360 degrees fits below 2^9
   localparam int HUE_INT_W = 9;

   // hue slope and sector offsets in degrees
   localparam int HUE_SLOPE    = 60;
   localparam int HUE_OFS_BLUE = 60;
   localparam int HUE_OFS_RED  = 180;
   localparam int HUE_OFS_GRN  = 300;

   // which channel is the smallest, tested blue, then red, then green
   typedef enum logic [1:0] {
      SEC_BLUE_MIN,
      SEC_RED_MIN,
      SEC_GREEN_MIN
   } sector_type;

endpackage

`default_nettype wire

>>> design/rgb_to_hsv_pixel.sv
// ============================================================================
// rgb_to_hsv_pixel
// Streaming bgr to hsv pixel conversion with a pipelined restoring divider.
// ============================================================================
// One pixel can enter every clock and one result leaves every clock while
// the result side keeps rsp_tready high. The pipeline stages are, in order,
// the input register, the channel sort, the hue numerator and divider load,
// the restoring divider stages (HUE_FRAC_BITS + 9 quotient bits), and the
// output register. Each stage holds its item when the next one is full and
// does not move, so a stall on the result side fills empty stages before
// req_tready drops.
// Value is the largest channel, saturation is max minus min (not
// normalized), and hue is in degrees with HUE_FRAC_BITS fraction bits,
// truncated, zero for a grey pixel, wrapped to 15 bits.
`default_nettype none

module rgb_to_hsv_pixel #(
   parameter int HUE_FRAC_BITS = rgb2hsv_pkg::HUE_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel in
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // blue [7:0], green [15:8], red [23:16]
   input  wire logic [rgb2hsv_pkg::REQ_DATA_W-1:0] req_tdata,
   // result out
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hue [14:0], saturation [22:15], brightness [30:23], zero [31]
   output logic [rgb2hsv_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import rgb2hsv_pkg::*;

   // quotient bits and scaled numerator width
   localparam int QW = HUE_INT_W + HUE_FRAC_BITS;
   localparam int NW = BASE_W + HUE_FRAC_BITS;

   // ---------------------------------------------------------------------
   // stage advance chain: a stage moves when empty or its successor moves
   // ---------------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic [QW:0]   dv_valid_ff;
   logic [QW:0]   dv_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          out_adv;
   logic [QW:0]   dv_adv;
   logic          s2_adv;
   logic          s1_adv;

   always_comb begin
      out_adv    = !rsp_valid_ff || rsp_tready;
      dv_adv[QW] = !dv_valid_ff[QW] || out_adv;
      for (int k = QW - 1; k >= 0; k--) begin
         dv_adv[k] = !dv_valid_ff[k] || dv_adv[k+1];
      end
      s2_adv = !s2_valid_ff || dv_adv[0];
      s1_adv = !s1_valid_ff || s2_adv;
   end

   assign req_tready = s1_adv;

   // ---------------------------------------------------------------------
   // stage 1: input register
   // ---------------------------------------------------------------------
   logic [CODE_W-1:0] s1_blue_ff, s1_blue_in;
   logic [CODE_W-1:0] s1_green_ff, s1_green_in;
   logic [CODE_W-1:0] s1_red_ff, s1_red_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_blue_in  = s1_blue_ff;
      s1_green_in = s1_green_ff;
      s1_red_in   = s1_red_ff;
      if (s1_adv) begin
         s1_valid_in = req_tvalid;
         s1_blue_in  = req_tdata[CODE_W-1:0];
         s1_green_in = req_tdata[2*CODE_W-1:CODE_W];
         s1_red_in   = req_tdata[3*CODE_W-1:2*CODE_W];
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: channel sort, span, sector and channel difference
   // ---------------------------------------------------------------------
   logic [CODE_W-1:0]        s2_max_ff, s2_max_in;
   logic [CODE_W-1:0]        s2_span_ff, s2_span_in;
   logic signed [CODE_W:0]   s2_delta_ff, s2_delta_in;
   sector_type               s2_sector_ff, s2_sector_in;

   logic [CODE_W-1:0]        max_w;
   logic [CODE_W-1:0]        min_w;

   always_comb begin
      max_w = s1_red_ff;
      min_w = s1_red_ff;
      if (s1_green_ff > max_w) max_w = s1_green_ff;
      if (s1_blue_ff > max_w)  max_w = s1_blue_ff;
      if (s1_green_ff < min_w) min_w = s1_green_ff;
      if (s1_blue_ff < min_w)  min_w = s1_blue_ff;

      s2_valid_in  = s2_valid_ff;
      s2_max_in    = s2_max_ff;
      s2_span_in   = s2_span_ff;
      s2_delta_in  = s2_delta_ff;
      s2_sector_in = s2_sector_ff;
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
         s2_max_in   = max_w;
         s2_span_in  = max_w - min_w;
         // tie on the minimum: blue first, then red
         if (min_w == s1_blue_ff) begin
            s2_sector_in = SEC_BLUE_MIN;
            s2_delta_in  = $signed({1'b0, s1_green_ff}) - $signed({1'b0, s1_red_ff});
         end else if (min_w == s1_red_ff) begin
            s2_sector_in = SEC_RED_MIN;
            s2_delta_in  = $signed({1'b0, s1_blue_ff}) - $signed({1'b0, s1_green_ff});
         end else begin
            s2_sector_in = SEC_GREEN_MIN;
            s2_delta_in  = $signed({1'b0, s1_red_ff}) - $signed({1'b0, s1_blue_ff});
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 3 (divider entry): numerator 60*delta + offset*span, scaled
   // ---------------------------------------------------------------------
   logic [CODE_W-1:0] dv_rem_ff  [0:QW];
   logic [CODE_W-1:0] dv_rem_in  [0:QW];
   logic [QW-1:0]     dv_work_ff [0:QW];
   logic [QW-1:0]     dv_work_in [0:QW];
   logic [CODE_W-1:0] dv_span_ff [0:QW];
   logic [CODE_W-1:0] dv_span_in [0:QW];
   logic [CODE_W-1:0] dv_max_ff  [0:QW];
   logic [CODE_W-1:0] dv_max_in  [0:QW];

   logic [BASE_W-1:0]        ofs_w;
   logic [BASE_W-1:0]        ofs_prod_w;
   logic signed [BASE_W:0]   slope_prod_w;
   logic signed [BASE_W:0]   base_sum_w;
   logic [NW-1:0]            num_w;

   always_comb begin
      case (s2_sector_ff)
         SEC_BLUE_MIN:  ofs_w = BASE_W'(HUE_OFS_BLUE);
         SEC_RED_MIN:   ofs_w = BASE_W'(HUE_OFS_RED);
         SEC_GREEN_MIN: ofs_w = BASE_W'(HUE_OFS_GRN);
         default:       ofs_w = '0;
      endcase
      ofs_prod_w   = ofs_w * BASE_W'(s2_span_ff);
      slope_prod_w = (BASE_W+1)'(s2_delta_ff) * $signed((BASE_W+1)'(HUE_SLOPE));
      // never negative: delta is at least minus span
      base_sum_w   = slope_prod_w + $signed({1'b0, ofs_prod_w});
      num_w        = NW'(base_sum_w[BASE_W-1:0]) << HUE_FRAC_BITS;

      dv_valid_in[0] = dv_valid_ff[0];
      dv_rem_in[0]   = dv_rem_ff[0];
      dv_work_in[0]  = dv_work_ff[0];
      dv_span_in[0]  = dv_span_ff[0];
      dv_max_in[0]   = dv_max_ff[0];
      if (dv_adv[0]) begin
         dv_valid_in[0] = s2_valid_ff;
         // quotient below 2^QW, so the top bits are already below span
         dv_rem_in[0]   = num_w[NW-1:QW];
         dv_work_in[0]  = num_w[QW-1:0];
         dv_span_in[0]  = s2_span_ff;
         dv_max_in[0]   = s2_max_ff;
      end
   end

   // ---------------------------------------------------------------------
   // restoring divider, one quotient bit per stage; work shifts out
   // numerator bits at the top and takes quotient bits at the bottom
   // ---------------------------------------------------------------------
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [CODE_W:0] trial_w;
      logic            take_w;

      always_comb begin
         trial_w = {dv_rem_ff[k-1], dv_work_ff[k-1][QW-1]};
         take_w  = trial_w >= {1'b0, dv_span_ff[k-1]};

         dv_valid_in[k] = dv_valid_ff[k];
         dv_rem_in[k]   = dv_rem_ff[k];
         dv_work_in[k]  = dv_work_ff[k];
         dv_span_in[k]  = dv_span_ff[k];
         dv_max_in[k]   = dv_max_ff[k];
         if (dv_adv[k]) begin
            dv_valid_in[k] = dv_valid_ff[k-1];
            dv_rem_in[k]   = take_w ? CODE_W'(trial_w - {1'b0, dv_span_ff[k-1]})
                                    : trial_w[CODE_W-1:0];
            dv_work_in[k]  = {dv_work_ff[k-1][QW-2:0], take_w};
            dv_span_in[k]  = dv_span_ff[k-1];
            dv_max_in[k]   = dv_max_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // output register: grey pixel forces hue to zero
   // ---------------------------------------------------------------------
   logic [HUE_W-1:0]  rsp_hue_ff, rsp_hue_in;
   logic [CODE_W-1:0] rsp_sat_ff, rsp_sat_in;
   logic [CODE_W-1:0] rsp_val_ff, rsp_val_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hue_in   = rsp_hue_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_val_in   = rsp_val_ff;
      if (out_adv) begin
         rsp_valid_in = dv_valid_ff[QW];
         rsp_hue_in   = (dv_span_ff[QW] == '0) ? '0 : HUE_W'(dv_work_ff[QW]);
         rsp_sat_in   = dv_span_ff[QW];
         rsp_val_in   = dv_max_ff[QW];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff, rsp_sat_ff, rsp_hue_ff};

   // ---------------------------------------------------------------------
   // registers: valid bits reset, payload free running
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         dv_valid_ff  <= dv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_blue_ff   <= s1_blue_in;
      s1_green_ff  <= s1_green_in;
      s1_red_ff    <= s1_red_in;
      s2_max_ff    <= s2_max_in;
      s2_span_ff   <= s2_span_in;
      s2_delta_ff  <= s2_delta_in;
      s2_sector_ff <= s2_sector_in;
      for (int k = 0; k <= QW; k++) begin
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_work_ff[k] <= dv_work_in[k];
         dv_span_ff[k] <= dv_span_in[k];
         dv_max_ff[k]  <= dv_max_in[k];
      end
      rsp_hue_ff <= rsp_hue_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_val_ff <= rsp_val_in;
   end

endmodule

`default_nettype wire

>>> tb/sv/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_to_hsv_pixel_tb
// Self-checking bench for the streaming bgr to hsv pixel converter. Directed
// pixels cover grey, primaries, ties for the smallest channel and hue near
// both ends of the range. Random pixels follow, with random gaps on both
// sides and one long stall on the result side. Each result is checked
// against an in-order queue of predicted hue, saturation and value.
// ============================================================================

module rgb_to_hsv_pixel_tb;

   import rgb2hsv_pkg::*;

   localparam int FRAC       = HUE_FRAC_BITS_DEF;
   localparam int N_RANDOM   = 1450;
   localparam int DRAIN_WAIT = FRAC + 40;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CODE_W-1:0] saturation;
      logic [CODE_W-1:0] brightness;
   } hsv_type;

   // expected results in transfer order, checked one by one
   class hsv_scoreboard;
      hsv_type hsv_pending[$];
      int      failures;

      function new();
         failures = 0;
      endfunction

      // exact integer hue, truncated to FRAC fraction bits, wrapped to 15 bits
      function hsv_type convert_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
         hsv_type    res;
         int         bi, gi, ri, mx, mn, span, delta, ofs;
         longint     num, quot;
         sector_type sec;
         bi = int'(b);
         gi = int'(g);
         ri = int'(r);
         mx = ri;
         mn = ri;
         if (gi > mx) mx = gi;
         if (bi > mx) mx = bi;
         if (gi < mn) mn = gi;
         if (bi < mn) mn = bi;
         span = mx - mn;
         res.saturation = span[7:0];
         res.brightness = mx[7:0];
         res.hue = '0;
         if (span != 0) begin
            // smallest channel picks the sector, blue before red before green
            if (mn == bi) sec = SEC_BLUE_MIN;
            else if (mn == ri) sec = SEC_RED_MIN;
            else sec = SEC_GREEN_MIN;
            case (sec)
               SEC_BLUE_MIN: begin
                  delta = gi - ri;
                  ofs = HUE_OFS_BLUE;
               end
               SEC_RED_MIN: begin
                  delta = bi - gi;
                  ofs = HUE_OFS_RED;
               end
               default: begin
                  delta = ri - bi;
                  ofs = HUE_OFS_GRN;
               end
            endcase
            num = (longint'(HUE_SLOPE) * delta + longint'(ofs) * span) * (64'sd1 << FRAC);
            if (num < 0) num = 0;
            quot = num / span;
            res.hue = quot[HUE_W-1:0];
         end
         return res;
      endfunction

      function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
         hsv_pending.push_back(convert_pixel(b, g, r));
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         hsv_type want;
         if (hsv_pending.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", data);
            failures++;
            return;
         end
         want = hsv_pending.pop_front();
         if (data[14:0] !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, data[14:0]);
            failures++;
         end
         if (data[22:15] !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, data[22:15]);
            failures++;
         end
         if (data[30:23] !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, data[30:23]);
            failures++;
         end
      endfunction

      function int pending();
         return hsv_pending.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   hsv_scoreboard hsv_board = new();
   int            results_seen = 0;

   rgb_to_hsv_pixel #(
      .HUE_FRAC_BITS(FRAC)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle cycles before the next transfer, none inside a burst
   function automatic int pick_gap(bit burst);
      return burst ? 0 : int'($urandom_range(0, 7));
   endfunction

   // offer one pixel and hold it until the transfer happens
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit burst);
      int gap;
      gap = pick_gap(burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, g, b};
      do @(posedge clock); while (!req_tready);
      hsv_board.note_pixel(b, g, r);
   endtask

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (results_seen == 400) gap = 150;
         else gap = pick_gap((results_seen / 128) % 3 == 1);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         hsv_board.check_result(rsp_tdata);
         results_seen++;
      end
   end

   // run limit
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] b, g, r, base;
      int         kind;
      bit         burst;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // grey pixels, primaries and full scale
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      // ties for the smallest or the largest channel
      send_pixel(8'd0, 8'd100, 8'd0, 1'b1);
      send_pixel(8'd50, 8'd50, 8'd200, 1'b1);
      send_pixel(8'd200, 8'd50, 8'd50, 1'b0);
      send_pixel(8'd200, 8'd200, 8'd50, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      // hue close to 360 and close to 0
      send_pixel(8'd1, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd1, 8'd255, 1'b0);
      // spans of one and two
      send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd1, 8'd0, 1'b1);
      send_pixel(8'd254, 8'd255, 8'd253, 1'b0);
      // alternating bit patterns, then small unequal channels
      send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
      send_pixel(8'd85, 8'd170, 8'd85, 1'b1);
      send_pixel(8'd3, 8'd7, 8'd11, 1'b1);

      // random pixels, biased toward ties, grey, small spans and channels near 0 or 255
      for (int i = 0; i < N_RANDOM; i++) begin
         burst = ((i / 100) % 3 == 0);
         kind = int'($urandom_range(0, 9));
         b = 8'($urandom_range(0, 255));
         g = 8'($urandom_range(0, 255));
         r = 8'($urandom_range(0, 255));
         case (kind)
            5: if ($urandom_range(0, 1)) g = b; else r = b;
            6: if ($urandom_range(0, 1)) r = g; else b = r;
            7: begin
               g = b;
               r = b;
            end
            8: begin
               base = 8'($urandom_range(0, 251));
               b = 8'(base + $urandom_range(0, 4));
               g = 8'(base + $urandom_range(0, 4));
               r = 8'(base + $urandom_range(0, 4));
            end
            9: begin
               b = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                        : 8'($urandom_range(0, 1));
               g = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                        : 8'($urandom_range(0, 1));
               r = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                        : 8'($urandom_range(0, 1));
            end
            default: ;
         endcase
         send_pixel(b, g, r, burst);
      end
      req_tvalid <= 1'b0;

      // drain, then give stray results time to show up
      while (hsv_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (hsv_board.failures == 0 && hsv_board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
